// File: hdl/blc_pkg.sv
// ----------------------------------------------------------------------------
// blc_pkg
// Shared types and constants of the blink-code LED pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

package blc_pkg;

  // Largest group of pulses in connected mode.
  localparam int MAX_LINKS = 8;

  localparam int DUR_W   = 16;
  localparam int CONN_W  = 4;
  localparam int CIDX_W  = 3;
  localparam int IDX_W   = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int LINK_W  = $clog2(MAX_LINKS + 1);
  localparam int CMP_W   = LINK_W + 1;

  // Request codes.
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [CIDX_W-1:0] REG_PAIRING_ON     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_PAIRING_OFF    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_CONNECTED_ON   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_CONNECTED_GAP  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_CONNECTED_PAUSE = 3'd4;
  localparam logic [CIDX_W-1:0] REG_IDLE_ON        = 3'd5;
  localparam logic [CIDX_W-1:0] REG_IDLE_OFF       = 3'd6;

  // Register reset values, milliseconds.
  localparam logic [DUR_W-1:0] RST_PAIRING_ON      = 16'd500;
  localparam logic [DUR_W-1:0] RST_PAIRING_OFF     = 16'd500;
  localparam logic [DUR_W-1:0] RST_CONNECTED_ON    = 16'd100;
  localparam logic [DUR_W-1:0] RST_CONNECTED_GAP   = 16'd200;
  localparam logic [DUR_W-1:0] RST_CONNECTED_PAUSE = 16'd1200;
  localparam logic [DUR_W-1:0] RST_IDLE_ON         = 16'd150;
  localparam logic [DUR_W-1:0] RST_IDLE_OFF        = 16'd2500;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_PAIRING   = 2'd1,
    MODE_CONNECTED = 2'd2
  } mode_t;

  typedef struct packed {
    logic [DUR_W-1:0] pairing_on;
    logic [DUR_W-1:0] pairing_off;
    logic [DUR_W-1:0] connected_on;
    logic [DUR_W-1:0] connected_gap;
    logic [DUR_W-1:0] connected_pause;
    logic [DUR_W-1:0] idle_on;
    logic [DUR_W-1:0] idle_off;
  } cfg_t;

  typedef struct packed {
    logic  led;
    mode_t mode;
    logic  phase_start;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/blc_cfg_regs.sv
// ----------------------------------------------------------------------------
// blc_cfg_regs
// Phase duration registers, written one at a time through the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module blc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  input  wire logic [blc_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [blc_pkg::DUR_W-1:0]   cfg_data,
  output blc_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pairing_on      <= blc_pkg::RST_PAIRING_ON;
      cfg.pairing_off     <= blc_pkg::RST_PAIRING_OFF;
      cfg.connected_on    <= blc_pkg::RST_CONNECTED_ON;
      cfg.connected_gap   <= blc_pkg::RST_CONNECTED_GAP;
      cfg.connected_pause <= blc_pkg::RST_CONNECTED_PAUSE;
      cfg.idle_on         <= blc_pkg::RST_IDLE_ON;
      cfg.idle_off        <= blc_pkg::RST_IDLE_OFF;
    end else if (cfg_valid) begin
      // Writes to an index past the last register are dropped.
      unique case (cfg_index)
        blc_pkg::REG_PAIRING_ON:      cfg.pairing_on      <= cfg_data;
        blc_pkg::REG_PAIRING_OFF:     cfg.pairing_off     <= cfg_data;
        blc_pkg::REG_CONNECTED_ON:    cfg.connected_on    <= cfg_data;
        blc_pkg::REG_CONNECTED_GAP:   cfg.connected_gap   <= cfg_data;
        blc_pkg::REG_CONNECTED_PAUSE: cfg.connected_pause <= cfg_data;
        blc_pkg::REG_IDLE_ON:         cfg.idle_on         <= cfg_data;
        blc_pkg::REG_IDLE_OFF:        cfg.idle_off        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/blc_core.sv
// ----------------------------------------------------------------------------
// blc_core
// Pattern state (LED level, blink index, phase timer, mode) and the
// combinational evaluation that advances it for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module blc_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire logic                        req_type,
  input  wire logic                        scan_active,
  input  wire logic [blc_pkg::CONN_W-1:0]  link_count,
  input  wire blc_pkg::cfg_t               cfg,
  output blc_pkg::result_t                 res
);

  logic                        led_level, led_level_next;
  logic [blc_pkg::IDX_W-1:0]   blink_index, blink_index_next;
  logic [blc_pkg::DUR_W-1:0]   time_left, time_left_next;
  blc_pkg::mode_t              mode_reg, mode_next;

  logic                        led_base;
  logic [blc_pkg::IDX_W-1:0]   idx_base;
  logic [blc_pkg::LINK_W-1:0]  links;
  logic [blc_pkg::CMP_W-1:0]   idx_inc;
  logic                        evaluate;
  logic [blc_pkg::DUR_W-1:0]   delay;

  always_comb begin
    // A restart starts a fresh group with the LED off.
    led_base = (req_type == blc_pkg::REQ_RESTART) ? 1'b0 : led_level;
    idx_base = (req_type == blc_pkg::REQ_RESTART) ? '0 : blink_index;
    evaluate = (req_type == blc_pkg::REQ_RESTART) || (time_left <= blc_pkg::DUR_W'(1));

    if (int'(link_count) > blc_pkg::MAX_LINKS) begin
      links = blc_pkg::LINK_W'(blc_pkg::MAX_LINKS);
    end else begin
      links = blc_pkg::LINK_W'(link_count);
    end
    idx_inc = blc_pkg::CMP_W'(idx_base) + blc_pkg::CMP_W'(1);

    led_level_next   = led_level;
    blink_index_next = idx_base;
    mode_next        = mode_reg;
    delay            = '0;

    if (scan_active) begin
      mode_next      = blc_pkg::MODE_PAIRING;
      delay          = led_base ? cfg.pairing_off : cfg.pairing_on;
      led_level_next = ~led_base;
    end else if (links == '0) begin
      mode_next      = blc_pkg::MODE_IDLE;
      delay          = led_base ? cfg.idle_off : cfg.idle_on;
      led_level_next = ~led_base;
    end else begin
      mode_next = blc_pkg::MODE_CONNECTED;
      if (led_base) begin
        led_level_next = 1'b0;
        // The group ends once the pulse count reaches the link count.
        if (idx_inc >= blc_pkg::CMP_W'(links)) begin
          blink_index_next = '0;
          delay            = cfg.connected_pause;
        end else begin
          blink_index_next = blc_pkg::IDX_W'(idx_inc);
          delay            = cfg.connected_gap;
        end
      end else begin
        led_level_next = 1'b1;
        delay          = cfg.connected_on;
      end
    end
    if (req_type == blc_pkg::REQ_TICK && !evaluate) begin
      led_level_next   = led_level;
      blink_index_next = blink_index;
      mode_next        = mode_reg;
      time_left_next   = time_left - blc_pkg::DUR_W'(1);
    end else begin
      time_left_next   = delay;
    end

    res.led         = led_level_next;
    res.mode        = mode_next;
    res.phase_start = evaluate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_level   <= 1'b0;
      blink_index <= '0;
      time_left   <= '0;
      mode_reg    <= blc_pkg::MODE_IDLE;
    end else if (fire) begin
      led_level   <= led_level_next;
      blink_index <= blink_index_next;
      time_left   <= time_left_next;
      mode_reg    <= mode_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    int'(blink_index) < blc_pkg::MAX_LINKS)
    else $error("blink index beyond the largest group");

  a_restart_lights: assert property (@(posedge clk) disable iff (rst)
    fire && req_type == blc_pkg::REQ_RESTART |=> led_level)
    else $error("restart did not light the LED");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    fire && req_type == blc_pkg::REQ_TICK && time_left > blc_pkg::DUR_W'(1)
    |=> $stable(led_level) && $stable(mode_reg)
        && time_left == $past(time_left) - blc_pkg::DUR_W'(1))
    else $error("plain tick changed more than the phase timer");

  a_idle_no_change: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(time_left) && $stable(blink_index))
    else $error("pattern state moved without a transfer");
`endif

endmodule

`default_nettype wire

// File: hdl/blink_code_led_pattern.sv
// ----------------------------------------------------------------------------
// blink_code_led_pattern
// Blink-code status LED generator: one result per tick or restart item.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (in_valid / in_stall) with req_type,
// scan_active and link_count; each transfer yields exactly one result on the
// output channel (out_valid / out_stall) with led, mode and phase_start.
// Phase durations are set through the config port (cfg_valid / cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high, and writes should be made
// while no item is in flight.
// An item passes an input register, then combinational evaluation against the
// pattern state, and lands in the output register. The pattern state is
// updated at the same edge that loads the output register, so one item per
// cycle is sustained while the receiver does not stall.
// When the receiver stalls, the result stays in the output register, one more
// item is held in the input register, and in_stall rises after that.
// Synchronous reset restores the register defaults, clears the core's LED level,
// sets idle mode and clears the phase timer so the first tick evaluates.
// ----------------------------------------------------------------------------
`default_nettype none

module blink_code_led_pattern (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        req_type,
  input  wire logic                        scan_active,
  input  wire logic [blc_pkg::CONN_W-1:0]  link_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             led,
  output logic [1:0]                       mode,
  output logic                             phase_start,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [blc_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [blc_pkg::DUR_W-1:0]   cfg_data
);

  blc_pkg::cfg_t               cfg;
  blc_pkg::result_t            res;
  blc_pkg::result_t            out_res;

  logic                        s1_valid;
  logic                        s1_req;
  logic                        s1_scan;
  logic [blc_pkg::CONN_W-1:0]  s1_conn;
  logic                        out_free;
  logic                        fire;
  logic                        in_take;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign fire      = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_take   = in_valid && !in_stall;

  blc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  blc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .req_type    (s1_req),
    .scan_active (s1_scan),
    .link_count  (s1_conn),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req  <= req_type;
      s1_scan <= scan_active;
      s1_conn <= link_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign led         = out_res.led;
  assign mode        = out_res.mode;
  assign phase_start = out_res.phase_start;

endmodule

`default_nettype wire
